// File: hw/rtl/tes_pkg.sv
// shared types and constants for the trace event scheduler
// no dependencies
package tes_pkg;

  localparam int NumProfiles       = 16;
  localparam int EntriesPerProfile = 64;
  localparam int NumSlots          = 16;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_SCHED = 2'd1,
    REQ_POP   = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_UPDATE,
    ST_OUT
  } state_e;

  // adds a signed delay to a date, saturating to the unsigned range
  function automatic logic [31:0] add_delay(logic [31:0] due, logic [31:0] dly);
    logic [32:0] sum;
    logic [32:0] dif;
    begin
      sum = {1'b0, due} + {1'b0, dly};
      dif = {1'b0, due} - {1'b0, (~dly) + 32'd1};
      if (dly[31]) begin
        add_delay = dif[32] ? 32'd0 : dif[31:0];
      end else begin
        add_delay = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      end
    end
  endfunction

endpackage

// File: hw/rtl/tes_cell.sv
// one slot cell of the minimum-search chain; compares its slot with the
// candidate passed from the left neighbor. depends on tes_pkg
module tes_cell
  import tes_pkg::*;
#(
  parameter int SlotW = 4
) (
  input  logic             active_i,
  input  logic [31:0]      due_i,
  input  logic [SlotW-1:0] idx_i,
  input  logic             any_i,
  input  logic [31:0]      best_due_i,
  input  logic [SlotW-1:0] best_idx_i,
  output logic             any_o,
  output logic [31:0]      best_due_o,
  output logic [SlotW-1:0] best_idx_o
);

  logic take;

  assign take       = active_i && (!any_i || (due_i < best_due_i));
  assign any_o      = any_i | active_i;
  assign best_due_o = take ? due_i : best_due_i;
  assign best_idx_o = take ? idx_i : best_idx_i;

endmodule

// File: hw/rtl/trace_event_scheduler.sv
// load, schedule and unknown requests go from accept straight to the result state; a pop
// first scans the slots, then reads the table and updates the slot before its result beat
// throughput: one item at a time, the next beat accepted with the result beat; a pop
// is set by the slot scan chain (a group of 4 cells per cycle), table read and write back
// reset: slots disarmed, profile lengths zero, table contents undefined
// depends on tes_pkg and tes_cell
module trace_event_scheduler
  import tes_pkg::*;
#(
  parameter int NUM_PROFILES        = NumProfiles,
  parameter int ENTRIES_PER_PROFILE = EntriesPerProfile,
  parameter int NUM_SLOTS           = NumSlots
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // req_type[1:0] profile_id[5:2] entry_index[11:6] entry_delay[43:12]
  // entry_value[75:44] is_last_entry[76] slot[80:77] resource_id[88:81]
  // query_date[120:89], zero fill to 128
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // found[0] event_slot[4:1] resource_out[12:5] value_out[44:13] freed[45],
  // zero fill to 48
  output logic [47:0]  m_axis_tdata
);

  localparam int PW  = (NUM_PROFILES > 1) ? $clog2(NUM_PROFILES) : 1;
  localparam int EW  = $clog2(ENTRIES_PER_PROFILE);
  localparam int SW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int LW  = EW + 1;
  localparam int AW  = PW + EW;
  localparam int TD  = NUM_PROFILES * ENTRIES_PER_PROFILE;
  localparam int GRP = 4;
  localparam int NG  = (NUM_SLOTS + GRP - 1) / GRP;
  localparam int GW  = (NG > 1) ? $clog2(NG) : 1;

  state_e state_q, state_d;

  logic [1:0]  req_q;
  logic [3:0]  prof_q;
  logic [5:0]  eidx_q;
  logic [31:0] dly_q, val_q, qdate_q;
  logic        last_q;
  logic [3:0]  slot_q;
  logic [7:0]  res_q;

  logic [LW-1:0] plen_q [NUM_PROFILES];
  logic [31:0]   due_q  [NUM_SLOTS];
  logic [EW-1:0] pos_q  [NUM_SLOTS];
  logic [PW-1:0] sprof_q[NUM_SLOTS];
  logic [7:0]    sres_q [NUM_SLOTS];
  logic          act_q  [NUM_SLOTS];

  logic [31:0] tdly_mem [TD];
  logic [31:0] tval_mem [TD];
  logic [31:0] rd_dly_q, rd_val_q;

  logic          any_q;
  logic [31:0]   bdue_q;
  logic [SW-1:0] bidx_q;
  logic [GW-1:0] grp_q;

  logic          out_v_q;
  logic [47:0]   out_q;

  logic          any_c   [GRP+1];
  logic [31:0]   bdue_c  [GRP+1];
  logic [SW-1:0] bidx_c  [GRP+1];

  logic in_acc;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  // a new beat may enter in the cycle the waiting result beat leaves
  assign s_axis_tready = (state_q == ST_IDLE) && (!out_v_q || m_axis_tready);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  assign any_c[0]  = any_q;
  assign bdue_c[0] = bdue_q;
  assign bidx_c[0] = bidx_q;

  for (genvar g = 0; g < GRP; g++) begin : g_cell
    localparam int Base = g;
    logic [SW+GW:0] sidx;
    logic           act;
    logic [31:0]    due;
    assign sidx = (SW+GW+1)'(grp_q) * (SW+GW+1)'(GRP) + (SW+GW+1)'(Base);
    assign act  = (sidx < (SW+GW+1)'(NUM_SLOTS)) ? act_q[sidx[SW-1:0]] : 1'b0;
    assign due  = due_q[sidx[SW-1:0]];
    tes_cell #(.SlotW(SW)) u_cell (
      .active_i  (act),
      .due_i     (due),
      .idx_i     (sidx[SW-1:0]),
      .any_i     (any_c[g]),
      .best_due_i(bdue_c[g]),
      .best_idx_i(bidx_c[g]),
      .any_o     (any_c[g+1]),
      .best_due_o(bdue_c[g+1]),
      .best_idx_o(bidx_c[g+1])
    );
  end

  // pop decode on the selected slot
  logic [PW-1:0] bp;
  logic [EW-1:0] bpos;
  logic [LW-1:0] blen;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          due_ok;
  logic          more, loop_ok;
  logic          freed;
  assign bp      = sprof_q[bidx_q];
  assign bpos    = pos_q[bidx_q];
  assign blen    = plen_q[bp];
  assign rd_addr = AW'(bp) * AW'(ENTRIES_PER_PROFILE) + AW'(bpos);
  assign wr_addr = AW'(prof_q[PW-1:0]) * AW'(ENTRIES_PER_PROFILE) + AW'(eidx_q[EW-1:0]);
  assign due_ok  = any_q && (bdue_q <= qdate_q);
  assign more    = ({1'b0, bpos} + LW'(1)) < blen;
  assign loop_ok = !rd_dly_q[31] && (rd_dly_q != 32'd0);
  assign freed   = !more && !loop_ok;

  logic ld_ok, sc_ok;
  assign ld_ok = ({28'd0, prof_q} < 32'(NUM_PROFILES)) &&
                 ({26'd0, eidx_q} < 32'(ENTRIES_PER_PROFILE));
  assign sc_ok = ({28'd0, slot_q} < 32'(NUM_SLOTS)) &&
                 ({28'd0, prof_q} < 32'(NUM_PROFILES)) &&
                 (plen_q[prof_q[PW-1:0]] != '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_acc) state_d = (req_e'(s_axis_tdata[1:0]) == REQ_POP) ?
                                       ST_SCAN : ST_OUT;
      ST_SCAN:   if (grp_q == GW'(NG - 1)) state_d = ST_READ;
      ST_READ:   state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_OUT;
      ST_OUT:    if (!out_v_q || m_axis_tready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && req_e'(req_q) == REQ_LOAD && ld_ok && !out_v_q) begin
      tdly_mem[wr_addr] <= dly_q;
      tval_mem[wr_addr] <= val_q;
    end
    rd_dly_q <= tdly_mem[rd_addr];
    rd_val_q <= tval_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q   <= s_axis_tdata[1:0];
      prof_q  <= s_axis_tdata[5:2];
      eidx_q  <= s_axis_tdata[11:6];
      dly_q   <= s_axis_tdata[43:12];
      val_q   <= s_axis_tdata[75:44];
      last_q  <= s_axis_tdata[76];
      slot_q  <= s_axis_tdata[80:77];
      res_q   <= s_axis_tdata[88:81];
      qdate_q <= s_axis_tdata[120:89];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_v_q <= 1'b0;
      out_q   <= '0;
      any_q   <= 1'b0;
      bdue_q  <= '0;
      bidx_q  <= '0;
      grp_q   <= '0;
      for (int i = 0; i < NUM_PROFILES; i++) plen_q[i] <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        act_q[i]   <= 1'b0;
        due_q[i]   <= '0;
        pos_q[i]   <= '0;
        sprof_q[i] <= '0;
        sres_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q != ST_OUT && m_axis_tready) out_v_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          any_q <= 1'b0;
          bdue_q <= '0;
          bidx_q <= '0;
          grp_q <= '0;
          if (in_acc) out_q <= '0;
        end
        ST_SCAN: begin
          any_q  <= any_c[GRP];
          bdue_q <= bdue_c[GRP];
          bidx_q <= bidx_c[GRP];
          if (grp_q != GW'(NG - 1)) grp_q <= grp_q + GW'(1);
        end
        ST_READ: ;
        ST_UPDATE: begin
          if (req_e'(req_q) == REQ_POP && due_ok) begin
            out_q <= {2'b00, freed, rd_val_q, sres_q[bidx_q], 4'(bidx_q), 1'b1};
            if (more) begin
              due_q[bidx_q] <= add_delay(bdue_q, rd_dly_q);
              pos_q[bidx_q] <= bpos + EW'(1);
            end else if (loop_ok) begin
              due_q[bidx_q] <= add_delay(bdue_q, rd_dly_q);
              pos_q[bidx_q] <= (blen >= LW'(2)) ? EW'(1) : EW'(0);
            end else begin
              act_q[bidx_q] <= 1'b0;
            end
          end
        end
        ST_OUT: begin
          if (!out_v_q || m_axis_tready) begin
            out_v_q <= 1'b1;
            if (req_e'(req_q) == REQ_LOAD && ld_ok && last_q)
              plen_q[prof_q[PW-1:0]] <= LW'(eidx_q[EW-1:0]) + LW'(1);
            if (req_e'(req_q) == REQ_SCHED && sc_ok) begin
              act_q[slot_q[SW-1:0]]   <= 1'b1;
              due_q[slot_q[SW-1:0]]   <= '0;
              pos_q[slot_q[SW-1:0]]   <= '0;
              sprof_q[slot_q[SW-1:0]] <= prof_q[PW-1:0];
              sres_q[slot_q[SW-1:0]]  <= res_q;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: tb/sv/trace_event_scheduler_test.sv
// testbench for trace_event_scheduler: random and directed request beats,
// result beats checked against a built-in predictor; depends on tes_pkg and trace_event_scheduler
`timescale 1ns / 1ps

class sched_scoreboard;
  logic [31:0] tbl_delay [1024];
  logic [31:0] tbl_value [1024];
  logic [6:0]  prof_len  [16];
  logic [31:0] s_due     [16];
  logic [5:0]  s_pos     [16];
  logic [3:0]  s_prof    [16];
  logic [7:0]  s_res     [16];
  bit          s_act     [16];
  logic [45:0] expected_results [$];
  int          fail_count;

  function new();
    for (int i = 0; i < 16; i++) begin
      prof_len[i] = '0; s_due[i] = '0; s_pos[i] = '0;
      s_prof[i] = '0; s_res[i] = '0; s_act[i] = 0;
    end
    fail_count = 0;
  endfunction

  function logic [31:0] sat_add(logic [31:0] due, logic [31:0] d);
    logic [32:0] sum;
    logic [31:0] mag;
    mag = (~d) + 32'd1;
    sum = {1'b0, due} + {1'b0, d};
    if (d[31]) return (due >= mag) ? due - mag : 32'd0;
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  function void note_request(logic [120:0] b);
    tes_pkg::req_e req;
    logic [3:0] prof, slot;
    logic [5:0] eidx;
    logic [31:0] d, v, q;
    logic [7:0] res;
    int best;
    bit any, fr;
    int a, len, pos;
    logic [45:0] r;
    req = tes_pkg::req_e'(b[1:0]);
    prof = b[5:2]; eidx = b[11:6]; d = b[43:12]; v = b[75:44];
    slot = b[80:77]; res = b[88:81]; q = b[120:89];
    r = '0;
    case (req)
      tes_pkg::REQ_LOAD: begin
        a = prof * 64 + eidx;
        tbl_delay[a] = d; tbl_value[a] = v;
        if (b[76]) prof_len[prof] = 7'(eidx) + 7'd1;
      end
      tes_pkg::REQ_SCHED: begin
        if (prof_len[prof] != 0) begin
          s_act[slot] = 1; s_due[slot] = 0; s_pos[slot] = 0;
          s_prof[slot] = prof; s_res[slot] = res;
        end
      end
      tes_pkg::REQ_POP: begin
        any = 0; best = 0;
        for (int s = 0; s < 16; s++)
          if (s_act[s] && (!any || s_due[s] < s_due[best])) begin
            best = s; any = 1;
          end
        if (any && s_due[best] <= q) begin
          pos = s_pos[best]; len = prof_len[s_prof[best]];
          a = s_prof[best] * 64 + pos;
          fr = 0;
          if (pos + 1 < len) begin
            s_due[best] = sat_add(s_due[best], tbl_delay[a]);
            s_pos[best] = 6'(pos + 1);
          end else if (!tbl_delay[a][31] && tbl_delay[a] != 0) begin
            s_due[best] = sat_add(s_due[best], tbl_delay[a]);
            s_pos[best] = (len >= 2) ? 6'd1 : 6'd0;
          end else begin
            s_act[best] = 0; fr = 1;
          end
          r = {fr, tbl_value[a], s_res[best], best[3:0], 1'b1};
        end
      end
      default: ;
    endcase
    expected_results = {expected_results, r};
  endfunction

  function void check_result(logic [47:0] got);
    logic [45:0] e;
    if (expected_results.size() == 0) begin
      $error("result beat with nothing expected: %h", got);
      fail_count++;
      return;
    end
    e = expected_results.pop_front();
    if (got[0] !== e[0]) begin
      $error("found: expected %0d actual %0d", e[0], got[0]); fail_count++;
    end
    if (got[4:1] !== e[4:1]) begin
      $error("event_slot: expected %0d actual %0d", e[4:1], got[4:1]); fail_count++;
    end
    if (got[12:5] !== e[12:5]) begin
      $error("resource_out: expected %0d actual %0d", e[12:5], got[12:5]); fail_count++;
    end
    if (got[44:13] !== e[44:13]) begin
      $error("value_out: expected %h actual %h", e[44:13], got[44:13]); fail_count++;
    end
    if (got[45] !== e[45]) begin
      $error("freed: expected %0d actual %0d", e[45], got[45]); fail_count++;
    end
  endfunction
endclass

module trace_event_scheduler_test;
  import tes_pkg::*;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [47:0]  m_axis_tdata;

  sched_scoreboard sb = new();
  bit   sink_calm = 0;
  bit   src_calm = 0;
  int   cycles = 0;
  int   src_gap = 0;
  bit   loaded [16][64];
  logic [31:0] clock_date = 0;

  localparam int CycleLimit = 400000;

  trace_event_scheduler dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("trace_event_scheduler verification failed");
      $finish;
    end
  end

  // result side: check on accept, random stall bursts
  int sink_gap = 0;
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      m_axis_tready <= 0;
    end else if (!sink_calm && $urandom_range(0, 9) == 0) begin
      sink_gap <= $urandom_range(1, 14);
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= rst_ni;
    end
  end

  // a pop must never read an entry that was never loaded
  function automatic bit pop_is_safe(logic [31:0] q);
    int best;
    bit any;
    any = 0; best = 0;
    for (int s = 0; s < 16; s++)
      if (sb.s_act[s] && (!any || sb.s_due[s] < sb.s_due[best])) begin
        best = s; any = 1;
      end
    if (!any || sb.s_due[best] > q) return 1;
    return loaded[sb.s_prof[best]][sb.s_pos[best]];
  endfunction

  task automatic send(logic [1:0] rq, logic [3:0] prof, logic [5:0] eidx, logic [31:0] d,
                      logic [31:0] v, bit last, logic [3:0] slot, logic [7:0] res,
                      logic [31:0] q);
    logic [120:0] b;
    if (rq == REQ_POP && !pop_is_safe(q)) rq = REQ_NONE;
    b = {q, res, slot, last, v, d, eidx, prof, rq};
    if (!src_calm && $urandom_range(0, 7) == 0) begin
      src_gap = $urandom_range(1, 14);
      s_axis_tvalid <= 0;
      repeat (src_gap) @(posedge clk_i);
    end
    s_axis_tdata <= {7'b0, b};
    s_axis_tvalid <= 1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(b);
    if (rq == REQ_LOAD) loaded[prof][eidx] = 1;
  endtask

  task automatic load_profile(logic [3:0] prof, int len, bit small_delays);
    logic [31:0] d;
    for (int i = 0; i < len; i++) begin
      d = small_delays ? $urandom_range(0, 50) : $urandom;
      if (i == len - 1 && $urandom_range(0, 2) == 0) d = 32'hFFFF_FFFF;
      send(REQ_LOAD, prof, 6'(i), d, $urandom, i == len - 1, 0, 0, 0);
    end
  endtask

  task automatic rand_pop();
    if ($urandom_range(0, 9) == 0) send(REQ_POP, 0, 0, 0, 0, 0, 0, 0, $urandom);
    else begin
      clock_date = clock_date + $urandom_range(0, 40);
      send(REQ_POP, 4'($urandom), 6'($urandom), $urandom, $urandom, 1'($urandom),
           4'($urandom), 8'($urandom), clock_date);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: empty pop, empty-profile schedule, unknown request, extremes
    send(REQ_POP, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
    send(REQ_SCHED, 4'd3, 0, 0, 0, 0, 4'd2, 8'hFF, 0);
    send(REQ_NONE, 4'hF, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 4'hF, 8'hFF, 32'hFFFF_FFFF);
    send(REQ_LOAD, 4'hF, 6'd0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0);
    send(REQ_LOAD, 4'hF, 6'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0, 0, 0);
    send(REQ_SCHED, 4'hF, 0, 0, 0, 0, 4'hF, 8'hA5, 0);
    send(REQ_SCHED, 4'hF, 0, 0, 0, 0, 4'd0, 8'h00, 0);
    repeat (6) send(REQ_POP, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
    // single entry looping on itself, then no-loop delay zero
    send(REQ_LOAD, 4'd0, 6'd0, 32'd5, 32'h0001_0000, 1, 0, 0, 0);
    send(REQ_SCHED, 4'd0, 0, 0, 0, 0, 4'd1, 8'd7, 0);
    send(REQ_POP, 0, 0, 0, 0, 0, 0, 0, 32'd0);
    send(REQ_POP, 0, 0, 0, 0, 0, 0, 0, 32'd4);
    send(REQ_POP, 0, 0, 0, 0, 0, 0, 0, 32'd5);
    send(REQ_LOAD, 4'd0, 6'd0, 32'd0, 32'hFFFF_0000, 1, 0, 0, 0);
    send(REQ_POP, 0, 0, 0, 0, 0, 0, 0, 32'd10);
    // length shrink below slot position: 6-entry profile cut to 1 mid-run
    load_profile(4'd1, 6, 1);
    send(REQ_SCHED, 4'd1, 0, 0, 0, 0, 4'd4, 8'd9, 0);
    send(REQ_POP, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
    send(REQ_POP, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
    send(REQ_LOAD, 4'd1, 6'd0, 32'd3, 32'd1, 1, 0, 0, 0);
    send(REQ_POP, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
    send(REQ_LOAD, 4'd1, 6'd63, 32'hFFFF_FFFF, 32'd2, 0, 0, 0, 0);

    for (int n = 0; n < 1500; n++) begin
      int k;
      if (n == 1300) src_calm = 1;
      if (n == 1300) sink_calm = 1;
      k = $urandom_range(0, 99);
      if (k < 8) load_profile(4'($urandom), $urandom_range(1, 5),
                              $urandom_range(0, 4) != 0);
      else if (k < 12) send(REQ_LOAD, 4'($urandom), 6'($urandom), $urandom, $urandom,
                            1'($urandom), 4'($urandom), 8'($urandom), $urandom);
      else if (k < 30) send(REQ_SCHED, 4'($urandom), 6'($urandom), $urandom, $urandom,
                            1'($urandom), 4'($urandom), 8'($urandom), $urandom);
      else if (k < 33) send(REQ_NONE, 4'($urandom), 6'($urandom), $urandom, $urandom,
                            1'($urandom), 4'($urandom), 8'($urandom), $urandom);
      else rand_pop();
    end
    s_axis_tvalid <= 0;

    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.expected_results.size() == 0)
      $display("trace_event_scheduler verification clean");
    else
      $display("trace_event_scheduler verification failed");
    $finish;
  end
endmodule
